// File: src/csl_pkg.sv
// Shared types, codes and default sizes for the context splice projection block.
// No dependencies; every other file of the block but csl_fifo imports this package.
`timescale 1ns / 1ps
`default_nettype none

package csl_pkg;

    // Default sizes of the stores
    localparam int MAX_FEATURES_DEF = 16;
    localparam int MAX_WINDOW_DEF   = 16;
    localparam int MAX_OUTPUTS_DEF  = 64;

    // Fixed field widths
    localparam int ROW_W      = 6;
    localparam int COLUMN_W   = 8;
    localparam int ELEM_W     = 4;
    localparam int SAMPLE_W   = 16;
    localparam int VALUE_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int LEFT_W     = 3;
    localparam int RIGHT_W    = 4;
    localparam int FEAT_W     = 5;
    localparam int OUTS_W     = 7;
    localparam int WIN_W      = 5;
    // Frame count saturates at right+1
    localparam int SEEN_W     = 5;

    localparam int CMD_QUEUE_DEPTH = 2;

    // Fraction bits dropped from the dot product
    localparam int FRAC_SHIFT = 14;

    localparam logic OP_LOAD    = 1'b0;
    localparam logic OP_FEATURE = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEFT     = 2'd0,
        REG_RIGHT    = 2'd1,
        REG_FEATURES = 2'd2,
        REG_OUTPUTS  = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_FEAT    = 2'd1,
        CMD_RESTART = 2'd2
    } cmd_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE    = 3'd0,
        ST_COPY_RD = 3'd1,
        ST_COPY_WR = 3'd2,
        ST_ISSUE   = 3'd3,
        ST_DRAIN   = 3'd4,
        ST_OUT     = 3'd5
    } back_state_t;

    typedef struct packed {
        cmd_kind_t                   kind;
        logic [ROW_W-1:0]            row;
        logic [COLUMN_W-1:0]         column;
        logic [ELEM_W-1:0]           elem;
        logic signed [SAMPLE_W-1:0]  value;
        logic                        ustart;
    } cmd_t;

    // Configuration after clamping to the store sizes
    typedef struct packed {
        logic [LEFT_W-1:0]  left;
        logic [RIGHT_W-1:0] right;
        logic [FEAT_W-1:0]  features;
        logic [OUTS_W-1:0]  outputs;
        logic [WIN_W-1:0]   window;
    } cfg_t;

endpackage

`default_nettype wire

// File: src/context_splice_linear_projection.sv
// Top level of the context splice linear projection block.
// Depends on csl_pkg, csl_front, csl_fifo and csl_back.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the left/right
//   context, feature count and output count; write it only while the block is idle.
//   item channel carries matrix loads (opcode 0) and feature coefficients (opcode 1).
//   result channel returns one result per projection row, last_of_frame on the last.
// Timing:
//   The front takes one request a cycle into a two-entry queue while it has room.
//   The back handles a load or a plain feature without leaving idle, ready for the
//   next request. The feature that completes an utterance's first frame starts a ring
//   copy into the earlier slots when left is nonzero.
//   A completed window runs one shared multiply-accumulate per product through the
//   single MAC and the ring/matrix read ports, one row at a time; window = left+right+1.
// Reset:
//   Clears control state, ring write slot and frame count; configuration returns to
//   left 3, right 3, features 13, outputs 40. Stores are undefined until written.
// Stall:
//   A held result keeps its register; the MAC waits before the next row while the
//   queue keeps taking requests until full.
`timescale 1ns / 1ps
`default_nettype none

module context_splice_linear_projection #(
    parameter int MAX_FEATURES = csl_pkg::MAX_FEATURES_DEF,
    parameter int MAX_WINDOW   = csl_pkg::MAX_WINDOW_DEF,
    parameter int MAX_OUTPUTS  = csl_pkg::MAX_OUTPUTS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [csl_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [csl_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  wire logic                                item_valid,
    output logic                                     item_ready,
    input  wire logic                                opcode,
    input  wire logic [csl_pkg::ROW_W-1:0]           matrix_row,
    input  wire logic [csl_pkg::COLUMN_W-1:0]        matrix_column,
    input  wire logic [csl_pkg::ELEM_W-1:0]          element_index,
    input  wire logic signed [csl_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                                utterance_start,
    output logic                                     result_valid,
    input  wire logic                                result_ready,
    output logic [csl_pkg::ROW_W-1:0]                output_index,
    output logic signed [csl_pkg::VALUE_W-1:0]       projected_value,
    output logic                                     last_of_frame
);

    import csl_pkg::*;

    // Front to queue
    logic push_valid, push_ready;
    cmd_t push_cmd;
    // Queue to back
    logic pop_valid, pop_ready;
    cmd_t pop_cmd;
    // Clamped configuration; the user must keep it static while work is in flight, the block does not enforce it
    cfg_t cfg;

    // Accept, hold config, and drop items that do nothing
    csl_front #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .item_valid      (item_valid),
        .item_ready      (item_ready),
        .opcode          (opcode),
        .matrix_row      (matrix_row),
        .matrix_column   (matrix_column),
        .element_index   (element_index),
        .sample_value    (sample_value),
        .utterance_start (utterance_start),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_cmd        (push_cmd),
        .cfg_out         (cfg)
    );

    // Decouple front and back
    csl_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CMD_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_cmd)
    );

    // Store, copy and project
    csl_back #(
        .MAX_FEATURES (MAX_FEATURES),
        .MAX_WINDOW   (MAX_WINDOW),
        .MAX_OUTPUTS  (MAX_OUTPUTS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd_valid       (pop_valid),
        .cmd_ready       (pop_ready),
        .cmd             (pop_cmd),
        .result_valid    (result_valid),
        .result_ready    (result_ready),
        .output_index    (output_index),
        .projected_value (projected_value),
        .last_of_frame   (last_of_frame)
    );

endmodule

`default_nettype wire

// File: src/csl_fifo.sv
// Small request queue between front and back of the projection block.
// Generic width; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module csl_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, rptr_reg;
    logic [CW-1:0]    count_reg;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wptr_reg <= (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rptr_reg <= (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: src/csl_front.sv
// Front end: configuration registers, clamping, and classification of input items.
// Depends on csl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csl_front #(
    parameter int MAX_FEATURES = csl_pkg::MAX_FEATURES_DEF,
    parameter int MAX_WINDOW   = csl_pkg::MAX_WINDOW_DEF,
    parameter int MAX_OUTPUTS  = csl_pkg::MAX_OUTPUTS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [csl_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [csl_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire logic                              opcode,
    input  wire logic [csl_pkg::ROW_W-1:0]         matrix_row,
    input  wire logic [csl_pkg::COLUMN_W-1:0]      matrix_column,
    input  wire logic [csl_pkg::ELEM_W-1:0]        element_index,
    input  wire logic signed [csl_pkg::SAMPLE_W-1:0] sample_value,
    input  wire logic                              utterance_start,
    output logic                                   push_valid,
    input  wire logic                              push_ready,
    output csl_pkg::cmd_t                          push_cmd,
    output csl_pkg::cfg_t                          cfg_out
);

    import csl_pkg::*;

    localparam int MAT_COLS = MAX_WINDOW * MAX_FEATURES;

    logic [LEFT_W-1:0]  left_reg;
    logic [RIGHT_W-1:0] right_reg;
    logic [FEAT_W-1:0]  feat_reg;
    logic [OUTS_W-1:0]  outs_reg;
    logic               keep;
    int                 right_lim;

    assign cfg_ready  = 1'b1;
    assign item_ready = push_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= LEFT_W'(3);
            right_reg <= RIGHT_W'(3);
            feat_reg  <= FEAT_W'(13);
            outs_reg  <= OUTS_W'(40);
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LEFT:     left_reg  <= cfg_data[LEFT_W-1:0];
                REG_RIGHT:    right_reg <= cfg_data[RIGHT_W-1:0];
                REG_FEATURES: feat_reg  <= cfg_data[FEAT_W-1:0];
                REG_OUTPUTS:  outs_reg  <= cfg_data[OUTS_W-1:0];
                default:      ;
            endcase
        end
    end

    // Clamp the registers to what the stores hold
    always_comb
    begin
        cfg_out.left = (int'(left_reg) > MAX_WINDOW - 1) ? LEFT_W'(MAX_WINDOW - 1) : left_reg;
        right_lim    = MAX_WINDOW - 1 - int'(cfg_out.left);
        cfg_out.right = (int'(right_reg) > right_lim) ? RIGHT_W'(right_lim) : right_reg;
        if (feat_reg == '0)
        begin
            cfg_out.features = FEAT_W'(1);
        end
        else if (int'(feat_reg) > MAX_FEATURES)
        begin
            cfg_out.features = FEAT_W'(MAX_FEATURES);
        end
        else
        begin
            cfg_out.features = feat_reg;
        end
        if (outs_reg == '0)
        begin
            cfg_out.outputs = OUTS_W'(1);
        end
        else if (int'(outs_reg) > MAX_OUTPUTS)
        begin
            cfg_out.outputs = OUTS_W'(MAX_OUTPUTS);
        end
        else
        begin
            cfg_out.outputs = outs_reg;
        end
        cfg_out.window = WIN_W'(cfg_out.left) + WIN_W'(cfg_out.right) + WIN_W'(1);
    end

    // Classify: drop loads outside the matrix and stray elements without a restart
    always_comb
    begin
        push_cmd.row    = matrix_row;
        push_cmd.column = matrix_column;
        push_cmd.elem   = element_index;
        push_cmd.value  = sample_value;
        push_cmd.ustart = utterance_start;
        keep            = 1'b1;
        if (opcode == OP_LOAD)
        begin
            push_cmd.kind = CMD_LOAD;
            keep = (int'(matrix_row) < MAX_OUTPUTS) && (int'(matrix_column) < MAT_COLS);
        end
        else if (FEAT_W'(element_index) < cfg_out.features)
        begin
            push_cmd.kind = CMD_FEAT;
        end
        else
        begin
            push_cmd.kind = CMD_RESTART;
            keep = utterance_start;
        end
    end

    assign push_valid = item_valid && keep;

endmodule

`default_nettype wire

// File: src/csl_back.sv
// Back end: frame ring, projection matrix, first-frame copy and the shared MAC.
// Depends on csl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module csl_back #(
    parameter int MAX_FEATURES = csl_pkg::MAX_FEATURES_DEF,
    parameter int MAX_WINDOW   = csl_pkg::MAX_WINDOW_DEF,
    parameter int MAX_OUTPUTS  = csl_pkg::MAX_OUTPUTS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire csl_pkg::cfg_t                  cfg,
    input  wire logic                           cmd_valid,
    output logic                                cmd_ready,
    input  wire csl_pkg::cmd_t                  cmd,
    output logic                                result_valid,
    input  wire logic                           result_ready,
    output logic [csl_pkg::ROW_W-1:0]           output_index,
    output logic signed [csl_pkg::VALUE_W-1:0]  projected_value,
    output logic                                last_of_frame
);

    import csl_pkg::*;

    localparam int MAT_COLS  = MAX_WINDOW * MAX_FEATURES;
    localparam int MAT_DEPTH = MAX_OUTPUTS * MAT_COLS;
    localparam int MAT_AW    = (MAT_DEPTH > 1) ? $clog2(MAT_DEPTH) : 1;
    localparam int RING_AW   = (MAT_COLS > 1) ? $clog2(MAT_COLS) : 1;
    localparam int SLOT_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int FE_W      = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = 32 + RING_AW;
    localparam int EXT_W     = ACC_W + 32;
    localparam logic signed [EXT_W-1:0] SAT_HI = {{(EXT_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [EXT_W-1:0] SAT_LO = {{(EXT_W-31){1'b1}}, {31{1'b0}}};

    function automatic logic [SLOT_W-1:0] slot_back(input logic [SLOT_W-1:0] slot,
                                                     input logic [WIN_W-1:0]  back);
        logic [SLOT_W+5:0] t;
        t = (SLOT_W+6)'(slot) + (SLOT_W+6)'(MAX_WINDOW) - (SLOT_W+6)'(back);
        if (t >= (SLOT_W+6)'(MAX_WINDOW))
        begin
            t = t - (SLOT_W+6)'(MAX_WINDOW);
        end
        return SLOT_W'(t);
    endfunction

    function automatic logic [RING_AW-1:0] ring_addr(input logic [SLOT_W-1:0] slot,
                                                      input logic [FEAT_W-1:0] e);
        return RING_AW'(slot) * RING_AW'(MAX_FEATURES) + RING_AW'(e);
    endfunction

    // Stores
    logic signed [SAMPLE_W-1:0] mat_mem  [MAT_DEPTH];
    logic signed [SAMPLE_W-1:0] ring_mem [MAT_COLS];
    logic signed [SAMPLE_W-1:0] mat_rd_reg, ring_rd_reg;

    logic                       mat_we, mat_re, ring_we, ring_re;
    logic [MAT_AW-1:0]          mat_waddr, mat_raddr;
    logic [RING_AW-1:0]         ring_waddr, ring_raddr;
    logic signed [SAMPLE_W-1:0] ring_wdata;

    back_state_t state_reg, state_next;

    logic [SLOT_W-1:0] slot_reg, cur_slot_reg, s_reg;
    logic [SEEN_W-1:0] seen_reg;
    logic              run_reg;
    logic [FE_W-1:0]   copy_e_reg;
    logic [LEFT_W-1:0] copy_j_reg;
    logic [ROW_W-1:0]  row_reg;
    logic [WIN_W-1:0]  j_reg;
    logic [FEAT_W-1:0] e_reg;
    logic [RING_AW-1:0] col_reg;

    logic p1_valid_reg, p1_first_reg, p1_last_reg;
    logic p2_valid_reg, p2_first_reg, p2_last_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     acc_done_reg;

    logic              result_valid_reg, last_reg;
    logic [ROW_W-1:0]  index_reg;
    logic signed [VALUE_W-1:0] value_reg;

    // Decode of the request at the head of the queue
    logic [WIN_W-1:0]  rp1;
    logic [SEEN_W-1:0] seen_eff, seen_use, seen_new;
    logic [SLOT_W-1:0] slot_use, slot_inc, cur_slot_next;
    logic              take, feat_cmd, elem_last, issue_last, out_free, mac_init, row_last;
    logic signed [EXT_W-1:0] q_ext;
    logic signed [VALUE_W-1:0] sat_val;

    always_comb
    begin
        rp1       = WIN_W'(cfg.right) + WIN_W'(1);
        seen_eff  = (WIN_W'(seen_reg) > rp1) ? SEEN_W'(rp1) : seen_reg;
        seen_use  = cmd.ustart ? '0 : seen_eff;
        slot_use  = cmd.ustart ? '0 : slot_reg;
        seen_new  = (WIN_W'(seen_use) < rp1) ? seen_use + 1'b1 : seen_use;
        slot_inc  = (slot_use == SLOT_W'(MAX_WINDOW - 1)) ? '0 : slot_use + 1'b1;
        take      = (state_reg == ST_IDLE) && cmd_valid;
        feat_cmd  = take && (cmd.kind == CMD_FEAT);
        elem_last = (FEAT_W'(cmd.elem) == cfg.features - FEAT_W'(1));
        cur_slot_next = (feat_cmd && elem_last) ? slot_use : cur_slot_reg;
        issue_last = (j_reg == cfg.window - WIN_W'(1)) &&
                     (e_reg == cfg.features - FEAT_W'(1));
        out_free  = !result_valid_reg || result_ready;
        row_last  = (OUTS_W'(row_reg) == cfg.outputs - OUTS_W'(1));
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (feat_cmd && elem_last)
                begin
                    if ((seen_use == '0) && (cfg.left != '0))
                    begin
                        state_next = ST_COPY_RD;
                    end
                    else if (WIN_W'(seen_new) == rp1)
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_COPY_RD:
            begin
                state_next = ST_COPY_WR;
            end
            ST_COPY_WR:
            begin
                if (copy_j_reg == cfg.left)
                begin
                    if (copy_e_reg == FE_W'(MAX_FEATURES - 1))
                    begin
                        state_next = run_reg ? ST_ISSUE : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_COPY_RD;
                    end
                end
            end
            ST_ISSUE:
            begin
                if (issue_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (acc_done_reg)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = row_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign mac_init = (state_next == ST_ISSUE) && (state_reg != ST_ISSUE);

    // Memory controls
    always_comb
    begin
        cmd_ready  = (state_reg == ST_IDLE);
        mat_we     = take && (cmd.kind == CMD_LOAD);
        mat_waddr  = MAT_AW'(cmd.row) * MAT_AW'(MAT_COLS) + MAT_AW'(cmd.column);
        mat_re     = (state_reg == ST_ISSUE);
        mat_raddr  = MAT_AW'(row_reg) * MAT_AW'(MAT_COLS) + MAT_AW'(col_reg);
        ring_we    = 1'b0;
        ring_waddr = ring_addr(slot_use, FEAT_W'(cmd.elem));
        ring_wdata = cmd.value;
        ring_re    = 1'b0;
        ring_raddr = ring_addr(s_reg, e_reg);
        case (state_reg)
            ST_IDLE:
            begin
                ring_we = feat_cmd;
            end
            ST_COPY_RD:
            begin
                ring_re    = 1'b1;
                ring_raddr = ring_addr(cur_slot_reg, FEAT_W'(copy_e_reg));
            end
            ST_COPY_WR:
            begin
                ring_we    = 1'b1;
                ring_waddr = ring_addr(slot_back(cur_slot_reg, WIN_W'(copy_j_reg)),
                                       FEAT_W'(copy_e_reg));
                ring_wdata = ring_rd_reg;
            end
            ST_ISSUE:
            begin
                ring_re = 1'b1;
            end
            default:
            begin
                ring_re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mat_we)
        begin
            mat_mem[mat_waddr] <= cmd.value;
        end
        if (mat_re)
        begin
            mat_rd_reg <= mat_mem[mat_raddr];
        end
        if (ring_we)
        begin
            ring_mem[ring_waddr] <= ring_wdata;
        end
        if (ring_re)
        begin
            ring_rd_reg <= ring_mem[ring_raddr];
        end
    end

    // Saturate the scaled sum
    always_comb
    begin
        q_ext = EXT_W'(acc_reg >>> FRAC_SHIFT);
        if (q_ext > SAT_HI)
        begin
            sat_val = {1'b0, {(VALUE_W-1){1'b1}}};
        end
        else if (q_ext < SAT_LO)
        begin
            sat_val = {1'b1, {(VALUE_W-1){1'b0}}};
        end
        else
        begin
            sat_val = q_ext[VALUE_W-1:0];
        end
    end

    // Product and accumulate stages
    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(mat_rd_reg) * PROD_W'(ring_rd_reg);
        if (p2_valid_reg)
        begin
            acc_reg <= p2_first_reg ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if (state_reg == ST_OUT && out_free)
        begin
            index_reg <= row_reg;
            value_reg <= sat_val;
            last_reg  <= row_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            slot_reg         <= '0;
            seen_reg         <= '0;
            cur_slot_reg     <= '0;
            run_reg          <= 1'b0;
            copy_e_reg       <= '0;
            copy_j_reg       <= '0;
            row_reg          <= '0;
            j_reg            <= '0;
            e_reg            <= '0;
            col_reg          <= '0;
            s_reg            <= '0;
            p1_valid_reg     <= 1'b0;
            p1_first_reg     <= 1'b0;
            p1_last_reg      <= 1'b0;
            p2_valid_reg     <= 1'b0;
            p2_first_reg     <= 1'b0;
            p2_last_reg      <= 1'b0;
            acc_done_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cur_slot_reg <= cur_slot_next;

            if (take && (cmd.kind == CMD_RESTART))
            begin
                slot_reg <= '0;
                seen_reg <= '0;
            end
            else if (feat_cmd)
            begin
                if (elem_last)
                begin
                    slot_reg   <= slot_inc;
                    seen_reg   <= seen_new;
                    run_reg    <= (WIN_W'(seen_new) == rp1);
                    copy_e_reg <= '0;
                end
                else
                begin
                    slot_reg <= slot_use;
                    seen_reg <= seen_use;
                end
            end

            // First-frame copy: one element read, then one write per earlier slot
            if (state_reg == ST_COPY_RD)
            begin
                copy_j_reg <= LEFT_W'(1);
            end
            else if (state_reg == ST_COPY_WR)
            begin
                if (copy_j_reg == cfg.left)
                begin
                    copy_e_reg <= copy_e_reg + 1'b1;
                end
                else
                begin
                    copy_j_reg <= copy_j_reg + 1'b1;
                end
            end

            // Product sequencer
            if (mac_init)
            begin
                j_reg        <= '0;
                e_reg        <= '0;
                col_reg      <= '0;
                s_reg        <= slot_back(cur_slot_next, cfg.window - WIN_W'(1));
                acc_done_reg <= 1'b0;
                row_reg      <= (state_reg == ST_OUT) ? row_reg + 1'b1 : '0;
            end
            else if (state_reg == ST_ISSUE)
            begin
                col_reg <= col_reg + 1'b1;
                if (e_reg == cfg.features - FEAT_W'(1))
                begin
                    e_reg <= '0;
                    j_reg <= j_reg + 1'b1;
                    s_reg <= (s_reg == SLOT_W'(MAX_WINDOW - 1)) ? '0 : s_reg + 1'b1;
                end
                else
                begin
                    e_reg <= e_reg + 1'b1;
                end
            end

            p1_valid_reg <= (state_reg == ST_ISSUE);
            p1_first_reg <= (col_reg == '0);
            p1_last_reg  <= issue_last;
            p2_valid_reg <= p1_valid_reg;
            p2_first_reg <= p1_first_reg;
            p2_last_reg  <= p1_last_reg;
            if (p2_valid_reg && p2_last_reg)
            begin
                acc_done_reg <= 1'b1;
            end

            if (state_reg == ST_OUT && out_free)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    assign result_valid    = result_valid_reg;
    assign output_index    = index_reg;
    assign projected_value = value_reg;
    assign last_of_frame   = last_reg;

endmodule

`default_nettype wire
